// ===== hdl/ata_transfer_address_setup_macros.svh =====
// Assertion macros used by the checker file of the ATA address setup block.
`ifndef ATA_TRANSFER_ADDRESS_SETUP_MACROS_SVH
`define ATA_TRANSFER_ADDRESS_SETUP_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ATAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ATAS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/atas_pkg.sv =====
// Package: types and constants of the ATA transfer address setup block.
package atas_pkg;

    localparam int BLK_W = 28;
    localparam int LIM_W = 29;
    localparam int SPT_W = 8;
    localparam int HPC_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] DH_BASE   = 8'hA0;
    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ONLINE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LBA_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPT          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HPC          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SELECT = 3'd4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NONE    = 2'd1,
        ST_OFFLINE = 2'd2
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] byte_offset;
        logic [31:0] byte_length;
        logic [27:0] partition_first;
        logic [28:0] partition_limit;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] sector_count;
        logic [7:0] sector_number;
        logic [7:0] cylinder_low;
        logic [7:0] cylinder_high;
        logic [7:0] drive_head;
        logic [7:0] command_code;
        logic [27:0] absolute_block;
    } out_word_t;

    typedef struct packed {
        logic             online;
        logic             lba;
        logic [SPT_W-1:0] spt;
        logic [HPC_W-1:0] hpc;
        logic             dsel;
    } cfg_t;

    // Request state carried down the divider chains
    typedef struct packed {
        logic             kind;
        logic             lba;
        logic             dsel;
        logic [HPC_W-1:0] hpc;
        status_t          status;
        logic [3:0]       count;
        logic [BLK_W-1:0] blk;
    } work_t;

    typedef struct packed {
        logic [SPT_W-1:0] sec_rem;
        work_t            w;
    } work2_t;

endpackage

// ===== hdl/atas_div_cell.sv =====
// One restoring-division cell: one quotient bit per cell, payload rides along.
module atas_div_cell #(
    parameter int DW = 28,
    parameter int VW = 8,
    parameter int PW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_num,
    input  logic [VW-1:0] in_rem,
    input  logic [VW-1:0] in_div,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_num,
    output logic [VW-1:0] out_rem,
    output logic [VW-1:0] out_div,
    output logic [PW-1:0] out_pay
);

    logic          valid_reg;
    logic [DW-1:0] num_reg, num_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] div_reg;
    logic [PW-1:0] pay_reg;
    logic [VW:0]   trial;
    logic          ge;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        trial    = {in_rem, in_num[DW-1]};
        ge       = trial >= {1'b0, in_div};
        rem_next = ge ? VW'(trial - {1'b0, in_div}) : trial[VW-1:0];
        num_next = {in_num[DW-2:0], ge};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            div_reg <= in_div;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== hdl/atas_front.sv =====
// Front cell: registers a request word, sizes the transfer and places it in the partition.
module atas_front #(
    parameter int SECTOR_BYTES = 512,
    parameter int MAX_TRANSFER_BYTES = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  atas_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  atas_pkg::in_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output atas_pkg::work_t    out_work,
    output logic [atas_pkg::SPT_W-1:0] out_spt
);
    import atas_pkg::*;

    localparam int SH = $clog2(SECTOR_BYTES);
    localparam int LW = $clog2(MAX_TRANSFER_BYTES + 1);
    localparam int CW = LW + 1;

    logic           valid_reg;
    in_word_t       word_reg;
    logic [LW-1:0]  len_cap;
    logic [CW-1:0]  len_rnd;
    logic [CW-1:0]  cnt;
    logic [CW-1:0]  cnt_clip;
    logic [LIM_W-1:0] blk;
    logic [LIM_W-1:0] room;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            word_reg <= in_word;
        end
    end

    // Cap, round to sectors, make absolute and clip at the partition end
    always_comb begin
        len_cap  = (word_reg.byte_length > 32'(MAX_TRANSFER_BYTES))
                   ? LW'(MAX_TRANSFER_BYTES) : word_reg.byte_length[LW-1:0];
        len_rnd  = CW'(len_cap) + CW'(SECTOR_BYTES - 1);
        cnt      = len_rnd >> SH;
        blk      = LIM_W'(word_reg.byte_offset >> SH) + LIM_W'(word_reg.partition_first);
        room     = word_reg.partition_limit - blk;
        cnt_clip = (LIM_W'(cnt) > room) ? CW'(room) : cnt;

        out_work.kind  = word_reg.kind;
        out_work.lba   = cfg.lba;
        out_work.dsel  = cfg.dsel;
        out_work.hpc   = (cfg.hpc == '0) ? HPC_W'(1) : cfg.hpc;
        out_work.count = cnt_clip[3:0];
        out_work.blk   = blk[BLK_W-1:0];
        priority if (!cfg.online) begin
            out_work.status = ST_OFFLINE;
        end else if (cnt == '0 || blk >= word_reg.partition_limit) begin
            out_work.status = ST_NONE;
        end else begin
            out_work.status = ST_OK;
        end
        out_spt = (cfg.spt == '0) ? SPT_W'(1) : cfg.spt;
    end

    assign out_valid = valid_reg;

endmodule

// ===== hdl/ata_transfer_address_setup.sv =====
// Top level: ATA transfer address setup, front cell, two divider cell chains, output register.
//
//   channel | ports                               | role
//   s_      | s_valid s_ready s_data              | request word in
//   m_      | m_valid m_ready m_data              | task-file word out
//   cfg_    | cfg_valid cfg_ready cfg_index cfg_wdata | register write
//
// A word passes 58 register stages: the front cell, 28 cells dividing by sectors per
// track, 28 cells dividing by heads per cylinder, and the output register.
// One word enters per cycle unless stalled; a cell moves on when the next is empty or moving.
// Reset (aresetn low, synchronous) empties every stage and loads register defaults.
// A stall on m_ready backs up the chain cell by cell; gaps close as words move.
module ata_transfer_address_setup #(
    parameter int SECTOR_BYTES = 512,
    parameter int MAX_TRANSFER_BYTES = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  atas_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output atas_pkg::out_word_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [atas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [atas_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import atas_pkg::*;

    localparam int NB = BLK_W;
    localparam int PB = $bits(work_t);
    localparam int PC = $bits(work2_t);

    cfg_t cfg_reg;

    // Take register writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.online <= 1'b0;
            cfg_reg.lba    <= 1'b0;
            cfg_reg.spt    <= SPT_W'(63);
            cfg_reg.hpc    <= HPC_W'(16);
            cfg_reg.dsel   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DRIVE_ONLINE: cfg_reg.online <= cfg_wdata[0];
                REG_LBA_MODE:     cfg_reg.lba    <= cfg_wdata[0];
                REG_SPT:          cfg_reg.spt    <= cfg_wdata[SPT_W-1:0];
                REG_HPC:          cfg_reg.hpc    <= cfg_wdata[HPC_W-1:0];
                REG_DRIVE_SELECT: cfg_reg.dsel   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Chain B: block / sectors per track
    logic             vb [0:NB];
    logic             rb [0:NB];
    logic [NB-1:0]    nb [0:NB];
    logic [SPT_W-1:0] mb [0:NB];
    logic [SPT_W-1:0] db [0:NB];
    logic [PB-1:0]    pb [0:NB];
    work_t            front_work;

    atas_front #(
        .SECTOR_BYTES(SECTOR_BYTES),
        .MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .in_valid(s_valid), .in_ready(s_ready), .in_word(s_data),
        .out_valid(vb[0]), .out_ready(rb[0]), .out_work(front_work), .out_spt(db[0])
    );

    assign nb[0] = front_work.blk;
    assign mb[0] = '0;
    assign pb[0] = front_work;

    // Chain C: (block / sectors per track) / heads per cylinder
    logic             vc [0:NB];
    logic             rc [0:NB];
    logic [NB-1:0]    nc [0:NB];
    logic [HPC_W-1:0] mc [0:NB];
    logic [HPC_W-1:0] dc [0:NB];
    logic [PC-1:0]    pc [0:NB];
    work_t            mid_work;
    work2_t           mid_pay;

    always_comb begin
        mid_work      = work_t'(pb[NB]);
        mid_pay.sec_rem = mb[NB];
        mid_pay.w     = mid_work;
    end

    assign vc[0] = vb[NB];
    assign rb[NB] = rc[0];
    assign nc[0] = nb[NB];
    assign mc[0] = '0;
    assign dc[0] = mid_work.hpc;
    assign pc[0] = mid_pay;

    for (genvar i = 0; i < NB; i++) begin : g_chain
        atas_div_cell #(.DW(NB), .VW(SPT_W), .PW(PB)) u_cell_b (
            .aclk(aclk), .aresetn(aresetn),
            .in_valid(vb[i]), .in_ready(rb[i]),
            .in_num(nb[i]), .in_rem(mb[i]), .in_div(db[i]), .in_pay(pb[i]),
            .out_valid(vb[i+1]), .out_ready(rb[i+1]),
            .out_num(nb[i+1]), .out_rem(mb[i+1]), .out_div(db[i+1]), .out_pay(pb[i+1])
        );
        atas_div_cell #(.DW(NB), .VW(HPC_W), .PW(PC)) u_cell_c (
            .aclk(aclk), .aresetn(aresetn),
            .in_valid(vc[i]), .in_ready(rc[i]),
            .in_num(nc[i]), .in_rem(mc[i]), .in_div(dc[i]), .in_pay(pc[i]),
            .out_valid(vc[i+1]), .out_ready(rc[i+1]),
            .out_num(nc[i+1]), .out_rem(mc[i+1]), .out_div(dc[i+1]), .out_pay(pc[i+1])
        );
    end

    // Output register: assemble the task-file word
    logic      m_valid_reg;
    out_word_t m_data_reg, m_data_next;
    work2_t    last_pay;
    logic [7:0]  sec;
    logic [15:0] cyl;
    logic [3:0]  head;

    assign rc[NB] = !m_valid_reg || m_ready;

    always_comb begin
        last_pay = work2_t'(pc[NB]);
        if (last_pay.w.lba) begin
            sec  = last_pay.w.blk[7:0];
            cyl  = last_pay.w.blk[23:8];
            head = last_pay.w.blk[27:24];
        end else begin
            sec  = last_pay.sec_rem + 8'd1;
            cyl  = nc[NB][15:0];
            head = mc[NB][3:0];
        end
        m_data_next = '0;
        m_data_next.status     = last_pay.w.status;
        m_data_next.drive_head = DH_BASE;
        if (last_pay.w.status == ST_OK) begin
            m_data_next.sector_count   = last_pay.w.count;
            m_data_next.sector_number  = sec;
            m_data_next.cylinder_low   = cyl[7:0];
            m_data_next.cylinder_high  = cyl[15:8];
            m_data_next.drive_head     = DH_BASE | {1'b0, last_pay.w.lba, 1'b0,
                                         last_pay.w.dsel, head};
            m_data_next.command_code   = last_pay.w.kind ? CMD_WRITE : CMD_READ;
            m_data_next.absolute_block = last_pay.w.blk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rc[NB]) begin
            m_valid_reg <= vc[NB];
        end
    end

    always_ff @(posedge aclk) begin
        if (rc[NB]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/atas_checker.sv =====
// Port checker for the ATA transfer address setup block, bound to the top level.
`include "ata_transfer_address_setup_macros.svh"

module atas_port_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input atas_pkg::out_word_t m_data
);
    import atas_pkg::*;

    // Hold a stalled result word
    `ATAS_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result word changed while stalled")

    // Failed requests carry only the base drive/head byte
    `ATAS_ASSERT(a_fail_clear, m_valid && m_data.status != ST_OK |-> m_data.sector_count == 4'd0 && m_data.command_code == 8'h00 && m_data.drive_head == DH_BASE, "failed word not cleared")

    // Good requests move at least one sector with a known command
    `ATAS_ASSERT(a_ok_word, m_valid && m_data.status == ST_OK |-> m_data.sector_count != 4'd0 && (m_data.command_code == CMD_READ || m_data.command_code == CMD_WRITE), "bad ok word")

    // No result right after reset
    `ATAS_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind ata_transfer_address_setup atas_port_checker u_atas_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
